>>> hdl/retransmit_timeout_estimator_unit_assert.svh
// ----------------------------------------------------------------------------
// retransmit timeout estimator assertion macros
// concurrent checks that can be compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef RETRANSMIT_TIMEOUT_ESTIMATOR_UNIT_ASSERT_SVH
`define RETRANSMIT_TIMEOUT_ESTIMATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RTE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rte assertion failed: same-cycle implication");

// next-cycle implication
`define RTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rte assertion failed: next-cycle implication");

`else

`define RTE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define RTE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hdl/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg
// shared types and constants of the retransmit timeout estimator
// ----------------------------------------------------------------------------
package rte_pkg;

   typedef enum logic [1:0] {
      CMD_RESTART    = 2'd0,
      CMD_NEW_PACKET = 2'd1,
      CMD_RESPONSE   = 2'd2,
      CMD_TIMEOUT    = 2'd3
   } cmd_type;

   localparam logic [1:0] CSR_MIN_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_MAX_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_RETRY_LIMIT = 2'd2;

   localparam int unsigned DEV_INIT_MS        = 750;
   localparam int unsigned RESTART_TIMEOUT_MS = 3000;
   localparam int unsigned MS_PER_SEC         = 1000;

   localparam logic [7:0]  RETRY_MAX = 8'hFF;
   localparam logic [15:0] MS_MAX    = 16'hFFFF;
   localparam logic [6:0]  SEC_MAX   = 7'h7F;

   // floor(y / 1000) == (y * SEC_RECIP) >> SEC_SHIFT for every y below 2^17
   localparam logic [17:0] SEC_RECIP = 18'd134218;
   localparam int unsigned SEC_SHIFT = 27;

   typedef struct packed {
      logic       give_up;
      logic [7:0] retries;
   } status_type;

endpackage

>>> hdl/rte_update.sv
// ----------------------------------------------------------------------------
// rte_update
// estimator state: srtt, deviation, timeout and retry count, updated per item
// ----------------------------------------------------------------------------
`include "retransmit_timeout_estimator_unit_assert.svh"

module rte_update
   import rte_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  cmd_type                   cmd,
   input  logic [23:0]               sample_ms,
   input  logic [15:0]               min_timeout_ms,
   input  logic [15:0]               max_timeout_ms,
   input  logic [7:0]                retry_limit,
   output logic [16+FRACTION_BITS-1:0] timeout_ff,
   output status_type                status
);

   localparam int unsigned EW = 24 + FRACTION_BITS;  // estimator width
   localparam int unsigned TW = 16 + FRACTION_BITS;  // timeout width
   localparam int unsigned CW = EW + 3;              // srtt + 4*dev
   localparam logic [EW-1:0] DEV_INIT = EW'(DEV_INIT_MS) << FRACTION_BITS;
   localparam logic [CW-1:0] RESTART_EST = CW'(RESTART_TIMEOUT_MS) << FRACTION_BITS;
   localparam logic [TW-1:0] TIMEOUT_RESET = TW'(RESTART_TIMEOUT_MS) << FRACTION_BITS;

   logic [EW-1:0]        srtt_ff, srtt_in;
   logic [EW-1:0]        dev_ff, dev_in;
   logic [TW-1:0]        timeout_in;
   logic [7:0]           retry_count_ff, retry_count_in;
   logic                 give_up_ff, give_up_in;

   logic [TW-1:0]        lo_bound, hi_bound;
   logic [EW-1:0]        meas;
   logic signed [EW:0]   delta, delta_mag, dev_diff, srtt_sum, dev_sum;
   logic [EW-1:0]        srtt_upd, dev_upd;
   logic [CW-1:0]        estimate;
   logic [7:0]           retry_inc;

   function automatic logic [TW-1:0] clamp_to_bounds(input logic [CW-1:0] t,
                                                      input logic [TW-1:0] lo,
                                                      input logic [TW-1:0] hi);
      logic [TW-1:0] r;
      // lower bound is tested first; when min exceeds max, t below min gets min, else max
      if (t < CW'(lo)) begin
         r = lo;
      end else if (t > CW'(hi)) begin
         r = hi;
      end else begin
         r = t[TW-1:0];
      end
      return r;
   endfunction

   assign lo_bound = {min_timeout_ms, {FRACTION_BITS{1'b0}}};
   assign hi_bound = {max_timeout_ms, {FRACTION_BITS{1'b0}}};

   // gain 1/8 on srtt, 1/4 on deviation, floor shifts
   assign meas      = {sample_ms, {FRACTION_BITS{1'b0}}};
   assign delta     = $signed({1'b0, meas}) - $signed({1'b0, srtt_ff});
   assign srtt_sum  = $signed({1'b0, srtt_ff}) + (delta >>> 3);
   assign srtt_upd  = srtt_sum[EW-1:0];
   assign delta_mag = delta[EW] ? -delta : delta;
   assign dev_diff  = $signed({1'b0, delta_mag[EW-1:0]}) - $signed({1'b0, dev_ff});
   assign dev_sum   = $signed({1'b0, dev_ff}) + (dev_diff >>> 2);
   assign dev_upd   = dev_sum[EW-1:0];
   assign estimate  = CW'(srtt_upd) + {1'b0, dev_upd, 2'b00};
   assign retry_inc = (retry_count_ff == RETRY_MAX) ? RETRY_MAX : retry_count_ff + 8'd1;

   always_comb begin
      srtt_in        = srtt_ff;
      dev_in         = dev_ff;
      timeout_in     = timeout_ff;
      retry_count_in = retry_count_ff;
      give_up_in     = 1'b0;
      case (cmd)
         CMD_RESTART: begin
            srtt_in    = '0;
            dev_in     = DEV_INIT;
            timeout_in = clamp_to_bounds(RESTART_EST, lo_bound, hi_bound);
         end
         CMD_NEW_PACKET: begin
            retry_count_in = '0;
         end
         CMD_RESPONSE: begin
            retry_count_in = '0;
            if (retry_count_ff != '0) begin
               // retransmitted packet: sample is ambiguous, timeout kept
               srtt_in = '0;
               dev_in  = DEV_INIT;
            end else begin
               srtt_in    = srtt_upd;
               dev_in     = dev_upd;
               timeout_in = clamp_to_bounds(estimate, lo_bound, hi_bound);
            end
         end
         CMD_TIMEOUT: begin
            timeout_in     = clamp_to_bounds(CW'({timeout_ff, 1'b0}), lo_bound, hi_bound);
            retry_count_in = retry_inc;
            give_up_in     = (retry_inc > retry_limit);
         end
         default: begin
            give_up_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srtt_ff        <= '0;
         dev_ff         <= DEV_INIT;
         timeout_ff     <= TIMEOUT_RESET;
         retry_count_ff <= '0;
      end else if (accept) begin
         srtt_ff        <= srtt_in;
         dev_ff         <= dev_in;
         timeout_ff     <= timeout_in;
         retry_count_ff <= retry_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         give_up_ff <= give_up_in;
      end
   end

   assign status.give_up = give_up_ff;
   assign status.retries = retry_count_ff;

   `RTE_ASSERT_NEXT(a_timeout_counts_retry, clock, reset, accept && cmd == CMD_TIMEOUT, retry_count_ff != '0)
   `RTE_ASSERT_NEXT(a_give_up_only_on_timeout, clock, reset, accept && cmd != CMD_TIMEOUT, !give_up_ff)
   `RTE_ASSERT_NEXT(a_retry_cleared, clock, reset, accept && (cmd == CMD_NEW_PACKET || cmd == CMD_RESPONSE), retry_count_ff == '0)

endmodule

>>> hdl/rte_convert.sv
// ----------------------------------------------------------------------------
// rte_convert
// result register: timeout rounded to ms and to whole seconds
// ----------------------------------------------------------------------------
module rte_convert
   import rte_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = 5
) (
   input  logic                        clock,
   input  logic                        load,
   input  logic [16+FRACTION_BITS-1:0] timeout,
   input  status_type                  status,
   output logic [6:0]                  timeout_seconds_ff,
   output logic [15:0]                 timeout_ms_ff,
   output logic                        give_up_ff,
   output logic [7:0]                  retries_ff
);

   localparam int unsigned TW = 16 + FRACTION_BITS;
   localparam logic [TW:0] HALF_MS  = (TW+1)'(1) << (FRACTION_BITS - 1);
   localparam logic [TW:0] HALF_SEC = (TW+1)'(MS_PER_SEC / 2) << FRACTION_BITS;

   logic [TW:0]   ms_sum, sec_sum;
   logic [16:0]   ms_round, sec_ms;
   logic [34:0]   sec_prod;
   logic [7:0]    sec_quot;
   logic [15:0]   ms_in;
   logic [6:0]    sec_in;

   assign ms_sum   = (TW+1)'(timeout) + HALF_MS;
   assign ms_round = ms_sum[TW:FRACTION_BITS];
   assign ms_in    = (ms_round > 17'(MS_MAX)) ? MS_MAX : ms_round[15:0];

   // half a second added before truncating to ms, then divided by 1000 via reciprocal
   assign sec_sum  = (TW+1)'(timeout) + HALF_SEC;
   assign sec_ms   = sec_sum[TW:FRACTION_BITS];
   assign sec_prod = 35'(sec_ms) * 35'(SEC_RECIP);
   assign sec_quot = sec_prod[SEC_SHIFT+7:SEC_SHIFT];
   assign sec_in   = (sec_quot > 8'(SEC_MAX)) ? SEC_MAX : sec_quot[6:0];

   always_ff @(posedge clock) begin
      if (load) begin
         timeout_seconds_ff <= sec_in;
         timeout_ms_ff      <= ms_in;
         give_up_ff         <= status.give_up;
         retries_ff         <= status.retries;
      end
   end

endmodule

>>> hdl/retransmit_timeout_estimator_unit.sv
// ----------------------------------------------------------------------------
// retransmit_timeout_estimator_unit
// smoothed rtt / deviation estimator producing the retransmission timeout
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one command (restart, new packet, response, timeout) and
//   an rtt sample in ms; rsp_* returns one result per command: timeout in
//   rounded seconds and ms, the give-up flag and the retry count.
//   csr_* writes min/max timeout bounds and the retry limit while idle;
//   writes apply from the next clamp on and leave the stored timeout as is.
// timing:
//   the estimator state updates at the accepting edge; the result register
//   loads when rsp is empty or taken; one item per cycle is sustained while
//   rsp_ready is high, set by the single state update stage.
// reset:
//   srtt 0, deviation 750 ms, timeout 3000 ms, retries 0, bounds 2000 and
//   60000 ms, retry limit 3; both pipeline stages empty.
// stall:
//   a held rsp keeps its result; one more item is taken into the state
//   stage, then req_ready drops until rsp_ready returns.
// ----------------------------------------------------------------------------
`include "retransmit_timeout_estimator_unit_assert.svh"

module retransmit_timeout_estimator_unit
   import rte_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [23:0] req_sample_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_timeout_seconds,
   output logic [15:0] rsp_timeout_ms,
   output logic        rsp_give_up,
   output logic [7:0]  rsp_retries,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic [15:0] MIN_TIMEOUT_RESET = 16'd2000;
   localparam logic [15:0] MAX_TIMEOUT_RESET = 16'd60000;
   localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd3;

   logic [15:0]  min_timeout_ff;
   logic [15:0]  max_timeout_ff;
   logic [7:0]   retry_limit_ff;

   logic         stage_valid_ff, stage_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         accept;
   logic         out_load;

   logic [16+FRACTION_BITS-1:0] timeout;
   status_type                  status;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_timeout_ff <= MIN_TIMEOUT_RESET;
         max_timeout_ff <= MAX_TIMEOUT_RESET;
         retry_limit_ff <= RETRY_LIMIT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MIN_TIMEOUT: min_timeout_ff <= csr_wdata;
            CSR_MAX_TIMEOUT: max_timeout_ff <= csr_wdata;
            CSR_RETRY_LIMIT: retry_limit_ff <= csr_wdata[7:0];
            default: begin
               min_timeout_ff <= min_timeout_ff;
            end
         endcase
      end
   end

   // state stage feeds the result register; both can hold an item
   assign out_load       = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready      = !stage_valid_ff || out_load;
   assign accept         = req_valid && req_ready;
   assign stage_valid_in = accept || (stage_valid_ff && !out_load);
   assign rsp_valid_in   = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   rte_update #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_update (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .cmd            (cmd_type'(req_cmd)),
      .sample_ms      (req_sample_ms),
      .min_timeout_ms (min_timeout_ff),
      .max_timeout_ms (max_timeout_ff),
      .retry_limit    (retry_limit_ff),
      .timeout_ff     (timeout),
      .status         (status)
   );

   rte_convert #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_convert (
      .clock              (clock),
      .load               (out_load),
      .timeout            (timeout),
      .status             (status),
      .timeout_seconds_ff (rsp_timeout_seconds),
      .timeout_ms_ff      (rsp_timeout_ms),
      .give_up_ff         (rsp_give_up),
      .retries_ff         (rsp_retries)
   );

   `RTE_ASSERT_IMPLIES(a_ready_low_only_when_full, clock, reset, !req_ready,
                       stage_valid_ff && rsp_valid_ff && !rsp_ready)
   `RTE_ASSERT_NEXT(a_accept_fills_stage, clock, reset, accept, stage_valid_ff)
   `RTE_ASSERT_NEXT(a_stage_moves_to_output, clock, reset,
                    stage_valid_ff && !rsp_valid_ff, rsp_valid_ff)

endmodule
